// ----- hdl/c_token_scanner_macros.svh -----
// Assertion macros shared by the scanner modules.
`ifndef C_TOKEN_SCANNER_MACROS_SVH
`define C_TOKEN_SCANNER_MACROS_SVH

`ifndef SYNTHESIS

`define CTOK_ASSERT(name, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("scanner assertion failed");

`define CTOK_NEVER(name, expr) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("scanner forbidden condition seen");

`else

`define CTOK_ASSERT(name, prop)

`define CTOK_NEVER(name, expr)

`endif

`endif

// ----- hdl/ctok_pkg.sv -----
package ctok_pkg;

    localparam int MAX_TOKEN_LEN = 255;
    localparam int LEN_W         = $clog2(MAX_TOKEN_LEN + 1);
    localparam int LENGTH_MAX    = 255;
    localparam int CH_W          = 8;
    localparam int KIND_W        = 3;
    localparam int LENGTH_W      = 8;

    localparam int FIFO_DEPTH = 2;
    localparam int PTR_W      = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [KIND_W-1:0] {
        K_IDENT     = 3'd0,
        K_INTEGER   = 3'd1,
        K_REAL      = 3'd2,
        K_EQUALITY  = 3'd3,
        K_ASSIGN    = 3'd4,
        K_DIRECTIVE = 3'd5
    } kind_t;

    typedef enum logic [3:0] {
        CLS_LETTER,
        CLS_DIGIT,
        CLS_UNDER,
        CLS_DOT,
        CLS_EQUALS,
        CLS_SLASH,
        CLS_HASH,
        CLS_STAR,
        CLS_NEWLINE,
        CLS_BLANK,
        CLS_SPACE,
        CLS_OTHER,
        CLS_END
    } cls_t;

    typedef enum logic [3:0] {
        M_IDLE,
        M_IDENT,
        M_INT,
        M_REAL,
        M_EQ,
        M_DIR,
        M_SLASH,
        M_LINE,
        M_BLOCK,
        M_STAR
    } scan_mode_t;

    typedef struct packed {
        logic valid;
        cls_t cls;
    } ctok_beat_t;

endpackage

// ----- hdl/ctok_if.sv -----
interface ctok_text_if import ctok_pkg::*;
();
    logic            valid;
    logic            ready;
    logic [CH_W-1:0] ch;
    logic            end_of_text;

    modport source (output valid, output ch, output end_of_text, input ready);
    modport sink   (input valid, input ch, input end_of_text, output ready);
endinterface

interface ctok_token_if import ctok_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   kind;
    logic [LENGTH_W-1:0] length;
    logic                truncated;

    modport source (output valid, output kind, output length, output truncated,
                    input ready);
    modport sink   (input valid, input kind, input length, input truncated,
                    output ready);
endinterface

// ----- hdl/ctok_front.sv -----
module ctok_front import ctok_pkg::*;
(
    ctok_text_if.sink  text,
    input  logic       full,
    output ctok_beat_t push
);

    localparam logic [CH_W-1:0] CH_DIGIT_LO = 8'd48;
    localparam logic [CH_W-1:0] CH_DIGIT_HI = 8'd57;
    localparam logic [CH_W-1:0] CH_UPPER_LO = 8'd65;
    localparam logic [CH_W-1:0] CH_UPPER_HI = 8'd90;
    localparam logic [CH_W-1:0] CH_LOWER_LO = 8'd97;
    localparam logic [CH_W-1:0] CH_LOWER_HI = 8'd122;
    localparam logic [CH_W-1:0] CH_BS       = 8'd8;
    localparam logic [CH_W-1:0] CH_TAB      = 8'd9;
    localparam logic [CH_W-1:0] CH_NL       = 8'd10;
    localparam logic [CH_W-1:0] CH_SPACE    = 8'd32;
    localparam logic [CH_W-1:0] CH_UNDER    = 8'h5F;
    localparam logic [CH_W-1:0] CH_DOT      = 8'h2E;
    localparam logic [CH_W-1:0] CH_HASH     = 8'h23;
    localparam logic [CH_W-1:0] CH_EQUALS   = 8'h3D;
    localparam logic [CH_W-1:0] CH_SLASH    = 8'h2F;
    localparam logic [CH_W-1:0] CH_STAR     = 8'h2A;

    cls_t cls;

    always_comb
    begin
        priority if (text.end_of_text)
            cls = CLS_END;
        else if ((text.ch >= CH_UPPER_LO && text.ch <= CH_UPPER_HI) ||
                 (text.ch >= CH_LOWER_LO && text.ch <= CH_LOWER_HI))
            cls = CLS_LETTER;
        else if (text.ch >= CH_DIGIT_LO && text.ch <= CH_DIGIT_HI)
            cls = CLS_DIGIT;
        else if (text.ch == CH_UNDER)
            cls = CLS_UNDER;
        else if (text.ch == CH_DOT)
            cls = CLS_DOT;
        else if (text.ch == CH_EQUALS)
            cls = CLS_EQUALS;
        else if (text.ch == CH_SLASH)
            cls = CLS_SLASH;
        else if (text.ch == CH_HASH)
            cls = CLS_HASH;
        else if (text.ch == CH_STAR)
            cls = CLS_STAR;
        else if (text.ch == CH_NL)
            cls = CLS_NEWLINE;
        else if (text.ch == CH_BS || text.ch == CH_TAB)
            cls = CLS_BLANK;
        else if (text.ch == CH_SPACE)
            cls = CLS_SPACE;
        else
            cls = CLS_OTHER;
    end

    assign text.ready = !full;
    assign push.valid = text.valid && !full;
    assign push.cls   = cls;

endmodule

// ----- hdl/ctok_fifo.sv -----
`include "c_token_scanner_macros.svh"

module ctok_fifo import ctok_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  ctok_beat_t push,
    output logic       full,
    output ctok_beat_t head,
    input  logic       pop
);

    cls_t             mem [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push.valid)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push.valid && !pop)
            count_next = count_reg + 1'b1;
        else if (!push.valid && pop)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
            mem[wr_ptr_reg] <= push.cls;
    end

    assign full       = (count_reg == CNT_W'(FIFO_DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.cls   = mem[rd_ptr_reg];

    `CTOK_ASSERT(a_fifo_bound, count_reg <= CNT_W'(FIFO_DEPTH))
    `CTOK_NEVER(a_fifo_pop_empty, pop && count_reg == '0)

endmodule

// ----- hdl/ctok_back.sv -----
`include "c_token_scanner_macros.svh"

module ctok_back import ctok_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  ctok_beat_t   head,
    output logic         pop,
    ctok_token_if.source token
);

    scan_mode_t          mode_reg;
    scan_mode_t          mode_next;
    logic [LEN_W-1:0]    len_reg;
    logic [LEN_W-1:0]    len_next;
    logic                seq_reg;
    logic                seq_next;
    logic                ovf_reg;
    logic                ovf_next;

    logic                out_valid_reg;
    logic                out_valid_next;
    kind_t               out_kind_reg;
    logic [LENGTH_W-1:0] out_length_reg;
    logic                out_trunc_reg;

    logic                emit;
    kind_t               emit_kind;
    logic                do_grow;
    logic                do_start;
    logic                eq_ok;
    kind_t               eq_kind;
    logic                ends_run;
    logic                word_char;
    scan_mode_t          start_mode;
    logic                len_sat;

    assign pop       = head.valid && (!out_valid_reg || token.ready);
    assign ends_run  = (head.cls == CLS_NEWLINE) || (head.cls == CLS_BLANK) ||
                       (head.cls == CLS_SPACE);
    assign word_char = (head.cls == CLS_LETTER) || (head.cls == CLS_DIGIT) ||
                       (head.cls == CLS_UNDER);
    assign eq_ok     = !ovf_reg && ((len_reg == LEN_W'(1)) ||
                       (len_reg == LEN_W'(2) && seq_reg));
    assign eq_kind   = (len_reg == LEN_W'(1)) ? K_ASSIGN : K_EQUALITY;
    assign len_sat   = (32'(len_reg) > 32'(LENGTH_MAX));

    always_comb
    begin
        unique case (head.cls)
            CLS_LETTER: start_mode = M_IDENT;
            CLS_DIGIT:  start_mode = M_INT;
            CLS_EQUALS: start_mode = M_EQ;
            CLS_SLASH:  start_mode = M_SLASH;
            CLS_HASH:   start_mode = M_DIR;
            default:    start_mode = M_IDLE;
        endcase
    end

    always_comb
    begin
        mode_next = mode_reg;
        len_next  = len_reg;
        seq_next  = seq_reg;
        ovf_next  = ovf_reg;
        emit      = 1'b0;
        emit_kind = K_IDENT;
        do_grow   = 1'b0;
        do_start  = 1'b0;
        if (pop)
        begin
            if (head.cls == CLS_END)
            begin
                unique case (mode_reg)
                    M_IDENT:
                    begin
                        emit      = 1'b1;
                        emit_kind = K_IDENT;
                    end
                    M_INT:
                    begin
                        emit      = 1'b1;
                        emit_kind = K_INTEGER;
                    end
                    M_REAL:
                    begin
                        emit      = 1'b1;
                        emit_kind = K_REAL;
                    end
                    M_DIR:
                    begin
                        emit      = 1'b1;
                        emit_kind = K_DIRECTIVE;
                    end
                    M_EQ:
                    begin
                        emit      = eq_ok;
                        emit_kind = eq_kind;
                    end
                    default:
                    begin
                        emit = 1'b0;
                    end
                endcase
                mode_next = M_IDLE;
                len_next  = '0;
                seq_next  = 1'b0;
                ovf_next  = 1'b0;
            end
            else
            begin
                unique case (mode_reg)
                    M_IDENT:
                    begin
                        if (word_char)
                            do_grow = 1'b1;
                        else
                        begin
                            emit      = 1'b1;
                            emit_kind = K_IDENT;
                            do_start  = 1'b1;
                        end
                    end
                    M_INT:
                    begin
                        if (head.cls == CLS_DIGIT)
                            do_grow = 1'b1;
                        else if (head.cls == CLS_DOT)
                        begin
                            do_grow   = 1'b1;
                            mode_next = M_REAL;
                        end
                        else
                        begin
                            emit      = 1'b1;
                            emit_kind = K_INTEGER;
                            do_start  = 1'b1;
                        end
                    end
                    M_REAL:
                    begin
                        if (head.cls == CLS_DIGIT)
                            do_grow = 1'b1;
                        else
                        begin
                            emit      = 1'b1;
                            emit_kind = K_REAL;
                            do_start  = 1'b1;
                        end
                    end
                    M_EQ:
                    begin
                        if (ends_run)
                        begin
                            emit      = eq_ok;
                            emit_kind = eq_kind;
                            do_start  = 1'b1;
                        end
                        else
                        begin
                            if (len_reg == LEN_W'(1) && head.cls == CLS_EQUALS)
                                seq_next = 1'b1;
                            do_grow = 1'b1;
                        end
                    end
                    M_DIR:
                    begin
                        if (ends_run)
                        begin
                            emit      = 1'b1;
                            emit_kind = K_DIRECTIVE;
                            do_start  = 1'b1;
                        end
                        else
                            do_grow = 1'b1;
                    end
                    M_SLASH:
                    begin
                        if (head.cls == CLS_SLASH)
                            mode_next = M_LINE;
                        else if (head.cls == CLS_STAR)
                            mode_next = M_BLOCK;
                        else
                            do_start = 1'b1;
                    end
                    M_LINE:
                    begin
                        if (head.cls == CLS_NEWLINE)
                            mode_next = M_IDLE;
                    end
                    M_BLOCK:
                    begin
                        if (head.cls == CLS_STAR)
                            mode_next = M_STAR;
                    end
                    M_STAR:
                    begin
                        if (head.cls == CLS_SLASH)
                            mode_next = M_IDLE;
                        else if (head.cls != CLS_STAR)
                            mode_next = M_BLOCK;
                    end
                    default:
                    begin
                        do_start = 1'b1;
                    end
                endcase

                if (do_grow)
                begin
                    if (32'(len_reg) < 32'(MAX_TOKEN_LEN))
                        len_next = len_reg + 1'b1;
                    else
                        ovf_next = 1'b1;
                end

                if (do_start)
                begin
                    mode_next = start_mode;
                    len_next  = (start_mode == M_IDLE) ? '0 : LEN_W'(1);
                    seq_next  = 1'b0;
                    ovf_next  = 1'b0;
                end
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (pop)
            out_valid_next = emit;
        else if (token.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= M_IDLE;
            len_reg       <= '0;
            seq_reg       <= 1'b0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mode_reg      <= mode_next;
            len_reg       <= len_next;
            seq_reg       <= seq_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && emit)
        begin
            out_kind_reg   <= emit_kind;
            out_length_reg <= len_sat ? LENGTH_W'(LENGTH_MAX) : LENGTH_W'(len_reg);
            out_trunc_reg  <= ovf_reg || len_sat;
        end
    end

    assign token.valid     = out_valid_reg;
    assign token.kind      = out_kind_reg;
    assign token.length    = out_length_reg;
    assign token.truncated = out_trunc_reg;

    `CTOK_ASSERT(a_eq_len, out_valid_reg && out_kind_reg == K_EQUALITY |-> out_length_reg == 8'd2)
    `CTOK_ASSERT(a_asg_len, out_valid_reg && out_kind_reg == K_ASSIGN |-> out_length_reg == 8'd1)

endmodule

// ----- hdl/c_token_scanner.sv -----
// Byte-serial scanner for C-like text: one byte per beat on text, one beat on
// token for each completed identifier, integer, real, "=", "==" or directive
// (kind, saturated length, truncation flag); comments and blanks give nothing.
// Sustained rate is one byte per clock cycle while token is not stalled, set
// by the mode update of the back-end scanner. A token comes out in the cycle
// after the queue hands over the byte (or end-of-text beat) that ends it, and
// the byte waits in a queue entry ahead of the output register. A two-beat
// queue between classifier and scanner and a registered output let input
// and output stall independently.
module c_token_scanner import ctok_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    ctok_text_if.sink    text,
    ctok_token_if.source token
);

    ctok_beat_t push;
    ctok_beat_t head;
    logic       full;
    logic       pop;

    ctok_front u_front (
        .text (text),
        .full (full),
        .push (push)
    );

    ctok_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (full),
        .head  (head),
        .pop   (pop)
    );

    ctok_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .head  (head),
        .pop   (pop),
        .token (token)
    );

endmodule
